// ===== rtl/core/sfp_pkg.sv =====
`default_nettype none
package sfp_pkg;

    localparam int HEAD_BYTES = 6;
    localparam int ID_ENTRIES = 5;

    localparam logic [7:0] SOF_FIRST    = 8'h5A;
    localparam logic [7:0] SOF_SECOND   = 8'hA5;
    localparam logic [7:0] TYPE_CONTROL = 8'h55;
    localparam logic [7:0] TYPE_STATUS  = 8'hAA;
    localparam logic [7:0] FIXED_LEN    = 8'd4;

    typedef struct packed {
        logic                            checksum_mode;
        logic [ID_ENTRIES-1:0][7:0]      id_table;
        logic [ID_ENTRIES-1:0]           id_enable_mask;
    } cfg_t;

    typedef struct packed {
        logic                            frame_class;
        logic [7:0]                      frame_ident;
        logic [HEAD_BYTES-1:0][7:0]      payload_head;
        logic [7:0]                      sequence_count;
        logic [7:0]                      received_sum;
        logic                            sum_ok;
        logic [7:0]                      payload_length;
    } result_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] sum, input logic [7:0] b,
                                             input logic mode);
        if (mode)
        begin
            return sum ^ b;
        end
        return sum + b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sfp_cfg_regs.sv =====
`default_nettype none
module sfp_cfg_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output sfp_pkg::cfg_t           cfg
);
    import sfp_pkg::*;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_ID_A = 3'd1;
    localparam logic [2:0] REG_ID_B = 3'd2;
    localparam logic [2:0] REG_ID_C = 3'd3;
    localparam logic [2:0] REG_ID_D = 3'd4;
    localparam logic [2:0] REG_ID_E = 3'd5;
    localparam logic [2:0] REG_MASK = 3'd6;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE: cfg_next.checksum_mode  = pwdata[0];
                REG_ID_A: cfg_next.id_table[0]    = pwdata[7:0];
                REG_ID_B: cfg_next.id_table[1]    = pwdata[7:0];
                REG_ID_C: cfg_next.id_table[2]    = pwdata[7:0];
                REG_ID_D: cfg_next.id_table[3]    = pwdata[7:0];
                REG_ID_E: cfg_next.id_table[4]    = pwdata[7:0];
                REG_MASK: cfg_next.id_enable_mask = pwdata[ID_ENTRIES-1:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE: prdata = {31'd0, cfg_reg.checksum_mode};
            REG_ID_A: prdata = {24'd0, cfg_reg.id_table[0]};
            REG_ID_B: prdata = {24'd0, cfg_reg.id_table[1]};
            REG_ID_C: prdata = {24'd0, cfg_reg.id_table[2]};
            REG_ID_D: prdata = {24'd0, cfg_reg.id_table[3]};
            REG_ID_E: prdata = {24'd0, cfg_reg.id_table[4]};
            REG_MASK: prdata = {27'd0, cfg_reg.id_enable_mask};
            default:  prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfp_parser.sv =====
`default_nettype none
module sfp_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_fire,
    input  wire logic [7:0]         rx_byte,
    input  wire sfp_pkg::cfg_t      cfg,
    output logic                    at_checksum,
    output logic                    res_fire,
    output sfp_pkg::result_t        res
);
    import sfp_pkg::*;

    localparam int         IDX_W   = $clog2(MAX_PAYLOAD + 1);
    localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 4);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_ID      = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_COUNT   = 3'd6;
    localparam logic [2:0] PH_CSUM    = 3'd7;

    logic [2:0]                 phase_reg,  phase_next;
    logic [7:0]                 length_reg, length_next;
    logic                       class_reg,  class_next;
    logic [7:0]                 ident_reg,  ident_next;
    logic [IDX_W-1:0]           idx_reg,    idx_next;
    logic [7:0]                 sum_reg,    sum_next;
    logic [HEAD_BYTES-1:0][7:0] head_reg,   head_next;
    logic [7:0]                 count_reg,  count_next;

    logic [7:0]       sum_fold;
    logic             id_hit;
    logic [IDX_W-1:0] idx_inc;
    logic [7:0]       plen;

    assign sum_fold    = fold_byte(sum_reg, rx_byte, cfg.checksum_mode);
    assign idx_inc     = idx_reg + 1'b1;
    assign plen        = length_reg - FIXED_LEN;
    assign at_checksum = (phase_reg == PH_CSUM);
    assign res_fire    = byte_fire && at_checksum;

    always_comb
    begin
        id_hit = 1'b0;
        for (int i = 0; i < ID_ENTRIES; i++)
        begin
            if (cfg.id_enable_mask[i] && cfg.id_table[i] == rx_byte)
            begin
                id_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        class_next  = class_reg;
        ident_next  = ident_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        if (byte_fire)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == SOF_FIRST)
                    begin
                        length_next = '0;
                        class_next  = 1'b0;
                        ident_next  = '0;
                        idx_next    = '0;
                        count_next  = '0;
                        head_next   = '0;
                        sum_next    = fold_byte(8'd0, rx_byte, cfg.checksum_mode);
                        phase_next  = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    if (rx_byte == SOF_SECOND)
                    begin
                        sum_next   = sum_fold;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LEN:
                begin
                    length_next = rx_byte;
                    if (rx_byte < FIXED_LEN || {1'b0, rx_byte} > LEN_MAX)
                    begin
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        sum_next   = sum_fold;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (rx_byte == TYPE_CONTROL || rx_byte == TYPE_STATUS)
                    begin
                        class_next = (rx_byte == TYPE_CONTROL);
                        sum_next   = sum_fold;
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_ID:
                begin
                    if (id_hit)
                    begin
                        ident_next = rx_byte;
                        sum_next   = sum_fold;
                        phase_next = (length_reg == FIXED_LEN) ? PH_COUNT : PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_PAYLOAD:
                begin
                    for (int k = 0; k < HEAD_BYTES; k++)
                    begin
                        if (idx_reg == IDX_W'(k))
                        begin
                            head_next[k] = rx_byte;
                        end
                    end
                    idx_next = idx_inc;
                    sum_next = sum_fold;
                    if (8'(idx_inc) >= plen)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    count_next = rx_byte;
                    sum_next   = sum_fold;
                    phase_next = PH_CSUM;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            length_reg <= '0;
            class_reg  <= 1'b0;
            ident_reg  <= '0;
            idx_reg    <= '0;
            sum_reg    <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            class_reg  <= class_next;
            ident_reg  <= ident_next;
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    // result is formed from the checksum byte plus the frame state
    always_comb
    begin
        res.frame_class    = class_reg;
        res.frame_ident    = ident_reg;
        res.payload_head   = head_reg;
        res.sequence_count = count_reg;
        res.received_sum   = rx_byte;
        res.sum_ok         = (rx_byte == sum_reg);
        res.payload_length = plen;
    end

`ifndef SYNTHESIS
    a_start_hunt2: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && phase_reg == PH_HUNT1 && rx_byte == SOF_FIRST) |=> phase_reg == PH_HUNT2)
        else $error("first start byte did not advance to second start byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (8'(idx_reg) < plen))
        else $error("payload index ran past frame length");

    a_csum_return: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> phase_reg == PH_HUNT1)
        else $error("parser did not return to hunt after checksum byte");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TYPE || phase_reg == PH_ID) |->
            (length_reg >= FIXED_LEN && {1'b0, length_reg} <= LEN_MAX))
        else $error("frame with illegal length kept in progress");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/serial_frame_parser_top.sv =====
`default_nettype none
// Serial frame parser. Takes one received byte per rx transaction and hunts for frames of the
// form 5A A5, length, type (55 control / AA status), id, payload, count, checksum. The id must
// hit an enabled entry of the five-entry id table; the running 8-bit checksum (sum, or XOR when
// checksum_mode is set) covers every byte before the checksum. Each checksum byte yields one
// result transaction carrying the first six payload bytes and sum_ok. One byte is taken per
// clock: the parser state updates in the cycle of the rx transaction and the result lands in a
// single output register the next cycle. Only a checksum byte waits on a full output register;
// every other byte is accepted while a result is still pending. Config registers sit at byte
// address 4*i on the APB port and should be written while no frame is in flight.
module serial_frame_parser_top #(
    parameter int MAX_PAYLOAD = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         rx_valid,
    output logic              rx_ready,
    input  wire logic [7:0]   rx_byte,
    output logic              res_valid,
    input  wire logic         res_ready,
    output logic              frame_class,
    output logic      [7:0]   frame_ident,
    output logic      [7:0]   payload_b0,
    output logic      [7:0]   payload_b1,
    output logic      [7:0]   payload_b2,
    output logic      [7:0]   payload_b3,
    output logic      [7:0]   payload_b4,
    output logic      [7:0]   payload_b5,
    output logic      [7:0]   sequence_count,
    output logic      [7:0]   received_sum,
    output logic              sum_ok,
    output logic      [7:0]   payload_length
);
    import sfp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    at_checksum;
    logic    byte_fire;
    logic    res_fire;
    logic    out_free;

    sfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .rx_byte     (rx_byte),
        .cfg         (cfg),
        .at_checksum (at_checksum),
        .res_fire    (res_fire),
        .res         (res)
    );

    assign out_free  = !out_valid_reg || res_ready;
    assign rx_ready  = out_free || !at_checksum;
    assign byte_fire = rx_valid && rx_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            out_reg <= res;
        end
    end

    assign res_valid      = out_valid_reg;
    assign frame_class    = out_reg.frame_class;
    assign frame_ident    = out_reg.frame_ident;
    assign payload_b0     = out_reg.payload_head[0];
    assign payload_b1     = out_reg.payload_head[1];
    assign payload_b2     = out_reg.payload_head[2];
    assign payload_b3     = out_reg.payload_head[3];
    assign payload_b4     = out_reg.payload_head[4];
    assign payload_b5     = out_reg.payload_head[5];
    assign sequence_count = out_reg.sequence_count;
    assign received_sum   = out_reg.received_sum;
    assign sum_ok         = out_reg.sum_ok;
    assign payload_length = out_reg.payload_length;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |-> !res_fire)
        else $error("pending result overwritten by new frame");

    a_fire_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> out_valid_reg)
        else $error("completed frame did not raise res_valid");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> (at_checksum && out_valid_reg && !res_ready))
        else $error("rx stalled without a blocked checksum byte");
`endif

endmodule
`default_nettype wire
